// ----- rtl/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, constants and sector codes of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   // Word field widths
   localparam int unsigned HueWidth  = 13;
   localparam int unsigned ChanWidth = 8;

   // Default hue resolution: 1/16 degree
   localparam int unsigned HUE_FRACTION_BITS_DEFAULT = 4;

   // One sector spans 60 degrees
   localparam int unsigned SECTOR_DEG = 60;

   // Reciprocal of 60 in 16 fraction bits, rounded down; one correction
   // step fixes the quotient for the value ranges seen here.
   localparam int unsigned RECIP_SHIFT = 16;
   localparam int unsigned RECIP_60    = (1 << RECIP_SHIFT) / SECTOR_DEG;
   localparam int unsigned RecipWidth  = $clog2(RECIP_60 + 1);

   // Hue below 2^13 gives at most sector 136 at full-degree resolution
   localparam int unsigned SectorWidth = 8;

   // Remainder after division by 60
   localparam int unsigned RemWidth = $clog2(SECTOR_DEG);

   // Depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;

   // Placement codes of (red, green, blue) before the offset is added
   typedef logic [2:0] sector_type;
   localparam sector_type SEC_C_X_0 = 3'd0;  // red to yellow
   localparam sector_type SEC_X_C_0 = 3'd1;  // yellow to green
   localparam sector_type SEC_0_C_X = 3'd2;  // green to cyan
   localparam sector_type SEC_0_X_C = 3'd3;  // cyan to blue
   localparam sector_type SEC_X_0_C = 3'd4;  // blue to magenta
   localparam sector_type SEC_C_0_X = 3'd5;  // magenta to red, and beyond

   localparam int unsigned SectorCodeWidth = $bits(sector_type);

endpackage

// ----- rtl/hsv2rgb_if.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_if
// Valid/ready channels of the HSV to RGB converter: HSV request words in,
// RGB response words out.
// ----------------------------------------------------------------------------
interface hsv2rgb_req_if;
   logic                               valid;
   logic                               ready;
   logic [hsv2rgb_pkg::HueWidth-1:0]   hue;
   logic [hsv2rgb_pkg::ChanWidth-1:0]  saturation;
   logic [hsv2rgb_pkg::ChanWidth-1:0]  brightness;

   modport source (output valid, hue, saturation, brightness, input ready);
   modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [hsv2rgb_pkg::ChanWidth-1:0]  red;
   logic [hsv2rgb_pkg::ChanWidth-1:0]  green;
   logic [hsv2rgb_pkg::ChanWidth-1:0]  blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

// ----- rtl/hsv2rgb_front.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_front
// Accept HSV words, form chroma and offset, split hue into sector and
// in-sector position, and hand a work word to the queue.
// ----------------------------------------------------------------------------
module hsv2rgb_front #(
   parameter int unsigned HUE_FRACTION_BITS = hsv2rgb_pkg::HUE_FRACTION_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   hsv2rgb_req_if.sink                          req_chan,
   output logic                                 wrk_valid,
   input  logic                                 wrk_ready,
   output logic [hsv2rgb_pkg::ChanWidth-1:0]    wrk_chroma,
   output logic [hsv2rgb_pkg::ChanWidth-1:0]    wrk_offset,
   output logic [$clog2((hsv2rgb_pkg::SECTOR_DEG << HUE_FRACTION_BITS) + 1)-1:0]
                                                wrk_ramp,
   output hsv2rgb_pkg::sector_type              wrk_sector
);

   localparam int unsigned Span      = hsv2rgb_pkg::SECTOR_DEG << HUE_FRACTION_BITS;
   localparam int unsigned SpanWidth = $clog2(Span + 1);
   localparam int unsigned HueW      = hsv2rgb_pkg::HueWidth;
   localparam int unsigned ChW       = hsv2rgb_pkg::ChanWidth;
   localparam int unsigned HkWidth   = HueW - HUE_FRACTION_BITS;
   localparam int unsigned HkProdW   = HkWidth + hsv2rgb_pkg::RecipWidth;
   localparam int unsigned VsWidth   = 2 * ChW;
   localparam int unsigned SecW      = hsv2rgb_pkg::SectorWidth;
   localparam int unsigned RemW      = hsv2rgb_pkg::RemWidth;
   localparam int unsigned SecCW     = hsv2rgb_pkg::SectorCodeWidth;
   localparam logic [HueW-1:0] LowMask = HueW'((1 << HUE_FRACTION_BITS) - 1);

   // Stage 1 registers
   logic                  s1_valid_ff;
   logic [HueW-1:0]       s1_hue_ff;
   logic [ChW-1:0]        s1_val_ff;
   logic [VsWidth-1:0]    s1_vs_ff;
   logic [HkProdW-1:0]    s1_hk_prod_ff;
   logic [VsWidth-1:0]    s1_vs_in;
   logic [HkProdW-1:0]    s1_hk_prod_in;
   logic [HkWidth-1:0]    s1_hk;

   // Stage 2 registers
   logic                  s2_valid_ff;
   logic [ChW-1:0]        s2_chroma_ff;
   logic [ChW-1:0]        s2_offset_ff;
   logic [SpanWidth-1:0]  s2_ramp_ff;
   hsv2rgb_pkg::sector_type s2_sector_ff;
   logic [ChW-1:0]        s2_chroma_in;
   logic [ChW-1:0]        s2_offset_in;
   logic [SpanWidth-1:0]  s2_ramp_in;
   hsv2rgb_pkg::sector_type s2_sector_in;

   logic                  s1_en;
   logic                  s2_en;

   logic [VsWidth:0]      chroma_sum;
   logic [SecW-1:0]       sec_est;
   logic [HkWidth:0]      rem_raw;
   logic                  rem_fix;
   logic [SecW-1:0]       sector_num;
   logic [RemW-1:0]       rem;
   logic [SpanWidth-1:0]  pos;

   // Advance a stage when it is empty or its word moves on
   assign s2_en          = !s2_valid_ff || wrk_ready;
   assign s1_en          = !s1_valid_ff || s2_en;
   assign req_chan.ready = s1_en;

   // Stage 1: value times saturation, and hue over 60 by reciprocal
   assign s1_hk         = HkWidth'(req_chan.hue >> HUE_FRACTION_BITS);
   assign s1_vs_in      = VsWidth'(req_chan.brightness) * VsWidth'(req_chan.saturation);
   assign s1_hk_prod_in = HkProdW'(s1_hk) * HkProdW'(hsv2rgb_pkg::RECIP_60);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_hue_ff     <= req_chan.hue;
         s1_val_ff     <= req_chan.brightness;
         s1_vs_ff      <= s1_vs_in;
         s1_hk_prod_ff <= s1_hk_prod_in;
      end
   end

   // Stage 2: exact divide by 255, sector correction, ramp position
   always_comb begin
      chroma_sum   = (VsWidth + 1)'(s1_vs_ff) + (VsWidth + 1)'(s1_vs_ff >> ChW) + 1'b1;
      s2_chroma_in = chroma_sum[VsWidth-1:ChW];
      s2_offset_in = s1_val_ff - s2_chroma_in;

      sec_est = SecW'(s1_hk_prod_ff >> hsv2rgb_pkg::RECIP_SHIFT);
      rem_raw = (HkWidth + 1)'(s1_hue_ff >> HUE_FRACTION_BITS)
              - (HkWidth + 1)'(32'(sec_est) * hsv2rgb_pkg::SECTOR_DEG);
      rem_fix = (rem_raw >= (HkWidth + 1)'(hsv2rgb_pkg::SECTOR_DEG));
      if (rem_fix) begin
         sector_num = sec_est + 1'b1;
         rem        = RemW'(rem_raw - (HkWidth + 1)'(hsv2rgb_pkg::SECTOR_DEG));
      end else begin
         sector_num = sec_est;
         rem        = RemW'(rem_raw);
      end

      pos = (SpanWidth'(rem) << HUE_FRACTION_BITS) | SpanWidth'(s1_hue_ff & LowMask);
      // Odd sectors ramp down
      if (sector_num[0]) begin
         s2_ramp_in = SpanWidth'(Span) - pos;
      end else begin
         s2_ramp_in = pos;
      end

      if (sector_num >= SecW'(hsv2rgb_pkg::SEC_C_0_X)) begin
         s2_sector_in = hsv2rgb_pkg::SEC_C_0_X;
      end else begin
         s2_sector_in = SecCW'(sector_num);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_chroma_ff <= s2_chroma_in;
         s2_offset_ff <= s2_offset_in;
         s2_ramp_ff   <= s2_ramp_in;
         s2_sector_ff <= s2_sector_in;
      end
   end

   assign wrk_valid  = s2_valid_ff;
   assign wrk_chroma = s2_chroma_ff;
   assign wrk_offset = s2_offset_ff;
   assign wrk_ramp   = s2_ramp_ff;
   assign wrk_sector = s2_sector_ff;

endmodule

// ----- rtl/hsv2rgb_queue.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_queue
// Small register queue between front and back; each side stalls on its own.
// ----------------------------------------------------------------------------
module hsv2rgb_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = hsv2rgb_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int unsigned PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CountWidth = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      store_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff;
   logic [PtrWidth-1:0]   rd_ptr_ff;
   logic [CountWidth-1:0] count_ff;
   logic [PtrWidth-1:0]   wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_in;
   logic [CountWidth-1:0] count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != CountWidth'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/hsv2rgb_back.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_back
// Scale chroma by the ramp position, divide by the sector span, place the
// components by sector, add the offset and hold the RGB word for the sink.
// ----------------------------------------------------------------------------
module hsv2rgb_back #(
   parameter int unsigned HUE_FRACTION_BITS = hsv2rgb_pkg::HUE_FRACTION_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wrk_valid,
   output logic                                 wrk_ready,
   input  logic [hsv2rgb_pkg::ChanWidth-1:0]    wrk_chroma,
   input  logic [hsv2rgb_pkg::ChanWidth-1:0]    wrk_offset,
   input  logic [$clog2((hsv2rgb_pkg::SECTOR_DEG << HUE_FRACTION_BITS) + 1)-1:0]
                                                wrk_ramp,
   input  hsv2rgb_pkg::sector_type              wrk_sector,
   hsv2rgb_rsp_if.source                        rsp_chan
);

   localparam int unsigned Span      = hsv2rgb_pkg::SECTOR_DEG << HUE_FRACTION_BITS;
   localparam int unsigned SpanWidth = $clog2(Span + 1);
   localparam int unsigned ChW       = hsv2rgb_pkg::ChanWidth;
   localparam int unsigned CgWidth   = ChW + SpanWidth;
   localparam int unsigned YWidth    = CgWidth - HUE_FRACTION_BITS;
   localparam int unsigned QProdW    = YWidth + hsv2rgb_pkg::RecipWidth;

   // Stage 1: chroma times ramp
   logic                    b1_valid_ff;
   logic [CgWidth-1:0]      b1_cg_ff;
   logic [ChW-1:0]          b1_chroma_ff;
   logic [ChW-1:0]          b1_offset_ff;
   hsv2rgb_pkg::sector_type b1_sector_ff;
   logic [CgWidth-1:0]      b1_cg_in;

   // Stage 2: drop the fraction bits, multiply by the reciprocal of 60
   logic                    b2_valid_ff;
   logic [YWidth-1:0]       b2_y_ff;
   logic [QProdW-1:0]       b2_qprod_ff;
   logic [ChW-1:0]          b2_chroma_ff;
   logic [ChW-1:0]          b2_offset_ff;
   hsv2rgb_pkg::sector_type b2_sector_ff;
   logic [YWidth-1:0]       b2_y_in;
   logic [QProdW-1:0]       b2_qprod_in;

   // Stage 3: output word
   logic                    b3_valid_ff;
   logic [ChW-1:0]          b3_red_ff;
   logic [ChW-1:0]          b3_green_ff;
   logic [ChW-1:0]          b3_blue_ff;
   logic [ChW-1:0]          b3_red_in;
   logic [ChW-1:0]          b3_green_in;
   logic [ChW-1:0]          b3_blue_in;

   logic                    b1_en;
   logic                    b2_en;
   logic                    b3_en;

   logic [ChW-1:0]          x_est;
   logic [YWidth-1:0]       x_rem;
   logic [ChW-1:0]          x_val;
   logic [ChW-1:0]          red_pre;
   logic [ChW-1:0]          green_pre;
   logic [ChW-1:0]          blue_pre;

   assign b3_en     = !b3_valid_ff || rsp_chan.ready;
   assign b2_en     = !b2_valid_ff || b3_en;
   assign b1_en     = !b1_valid_ff || b2_en;
   assign wrk_ready = b1_en;

   assign b1_cg_in    = CgWidth'(wrk_chroma) * CgWidth'(wrk_ramp);
   assign b2_y_in     = YWidth'(b1_cg_ff >> HUE_FRACTION_BITS);
   assign b2_qprod_in = QProdW'(b2_y_in) * QProdW'(hsv2rgb_pkg::RECIP_60);

   // Quotient estimate is low by at most one; correct it with one compare
   always_comb begin
      x_est = ChW'(b2_qprod_ff >> hsv2rgb_pkg::RECIP_SHIFT);
      x_rem = b2_y_ff - YWidth'(32'(x_est) * hsv2rgb_pkg::SECTOR_DEG);
      if (x_rem >= YWidth'(hsv2rgb_pkg::SECTOR_DEG)) begin
         x_val = x_est + 1'b1;
      end else begin
         x_val = x_est;
      end

      case (b2_sector_ff)
         hsv2rgb_pkg::SEC_C_X_0: begin
            red_pre = b2_chroma_ff; green_pre = x_val;        blue_pre = '0;
         end
         hsv2rgb_pkg::SEC_X_C_0: begin
            red_pre = x_val;        green_pre = b2_chroma_ff; blue_pre = '0;
         end
         hsv2rgb_pkg::SEC_0_C_X: begin
            red_pre = '0;           green_pre = b2_chroma_ff; blue_pre = x_val;
         end
         hsv2rgb_pkg::SEC_0_X_C: begin
            red_pre = '0;           green_pre = x_val;        blue_pre = b2_chroma_ff;
         end
         hsv2rgb_pkg::SEC_X_0_C: begin
            red_pre = x_val;        green_pre = '0;           blue_pre = b2_chroma_ff;
         end
         default: begin
            red_pre = b2_chroma_ff; green_pre = '0;           blue_pre = x_val;
         end
      endcase

      // Chroma plus offset equals brightness, so these never wrap
      b3_red_in   = red_pre + b2_offset_ff;
      b3_green_in = green_pre + b2_offset_ff;
      b3_blue_in  = blue_pre + b2_offset_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
      end else begin
         if (b1_en) begin
            b1_valid_ff <= wrk_valid;
         end
         if (b2_en) begin
            b2_valid_ff <= b1_valid_ff;
         end
         if (b3_en) begin
            b3_valid_ff <= b2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b1_en) begin
         b1_cg_ff     <= b1_cg_in;
         b1_chroma_ff <= wrk_chroma;
         b1_offset_ff <= wrk_offset;
         b1_sector_ff <= wrk_sector;
      end
      if (b2_en) begin
         b2_y_ff      <= b2_y_in;
         b2_qprod_ff  <= b2_qprod_in;
         b2_chroma_ff <= b1_chroma_ff;
         b2_offset_ff <= b1_offset_ff;
         b2_sector_ff <= b1_sector_ff;
      end
      if (b3_en) begin
         b3_red_ff    <= b3_red_in;
         b3_green_ff  <= b3_green_in;
         b3_blue_ff   <= b3_blue_in;
      end
   end

   assign rsp_chan.valid = b3_valid_ff;
   assign rsp_chan.red   = b3_red_ff;
   assign rsp_chan.green = b3_green_ff;
   assign rsp_chan.blue  = b3_blue_ff;

endmodule

// ----- rtl/hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// HSV pixel to 8-bit RGB pixel, one word per clock unless stalled, fixed-point throughout.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake            payload
//   --------  ---  -------------------  -----------------------------------
//   req_chan  in   valid/ready          hue[12:0], saturation[7:0],
//                                       brightness[7:0]
//   rsp_chan  out  valid/ready          red[7:0], green[7:0], blue[7:0]
//
// Takes one request word every clock while req_chan.ready is high, and returns
// one response word for it, in order. Each request word passes six registers
// on its way to the response (two front stages, one queue slot, three back
// stages with the output register last), the first loaded at the accepting
// edge.
// Throughput is not limited by the multipliers; none of them iterates.
// Synchronous reset empties all stages and the queue.
// A stall on rsp_chan first fills the back stages, then the 4-word queue,
// then the front stages, and only then drops req_chan.ready.
//
// Arithmetic (all divisions truncate):
//   chroma = brightness*saturation/255, offset = brightness - chroma
//   sector = hue / (60 << HUE_FRACTION_BITS), pos = remainder
//   x      = chroma*ramp / span, ramp = pos (even sector) or span - pos (odd)
// Division by 255 uses the add-and-shift identity; division by 60 uses a
// reciprocal multiply followed by one compare-and-correct step.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter #(
   parameter int unsigned HUE_FRACTION_BITS = hsv2rgb_pkg::HUE_FRACTION_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   hsv2rgb_req_if.sink   req_chan,
   hsv2rgb_rsp_if.source rsp_chan
);

   localparam int unsigned Span      = hsv2rgb_pkg::SECTOR_DEG << HUE_FRACTION_BITS;
   localparam int unsigned SpanWidth = $clog2(Span + 1);
   localparam int unsigned ChW       = hsv2rgb_pkg::ChanWidth;
   localparam int unsigned SecCW     = hsv2rgb_pkg::SectorCodeWidth;
   localparam int unsigned WorkWidth = 2 * ChW + SpanWidth + SecCW;

   // Front to queue
   logic                    fq_valid;
   logic                    fq_ready;
   logic [ChW-1:0]          fq_chroma;
   logic [ChW-1:0]          fq_offset;
   logic [SpanWidth-1:0]    fq_ramp;
   hsv2rgb_pkg::sector_type fq_sector;
   logic [WorkWidth-1:0]    fq_word;

   // Queue to back
   logic                    qb_valid;
   logic                    qb_ready;
   logic [WorkWidth-1:0]    qb_word;
   logic [ChW-1:0]          qb_chroma;
   logic [ChW-1:0]          qb_offset;
   logic [SpanWidth-1:0]    qb_ramp;
   hsv2rgb_pkg::sector_type qb_sector;

   // Front: accept the pixel, form chroma, offset, sector and ramp
   hsv2rgb_front #(
      .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .wrk_valid  (fq_valid),
      .wrk_ready  (fq_ready),
      .wrk_chroma (fq_chroma),
      .wrk_offset (fq_offset),
      .wrk_ramp   (fq_ramp),
      .wrk_sector (fq_sector)
   );

   assign fq_word = {fq_chroma, fq_offset, fq_ramp, fq_sector};

   // Queue: decouple the two halves
   hsv2rgb_queue #(
      .WIDTH (WorkWidth),
      .DEPTH (hsv2rgb_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_word),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_word)
   );

   assign {qb_chroma, qb_offset, qb_ramp, qb_sector} = qb_word;

   // Back: scale, divide, place and add the offset
   hsv2rgb_back #(
      .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .wrk_valid  (qb_valid),
      .wrk_ready  (qb_ready),
      .wrk_chroma (qb_chroma),
      .wrk_offset (qb_offset),
      .wrk_ramp   (qb_ramp),
      .wrk_sector (qb_sector),
      .rsp_chan   (rsp_chan)
   );

endmodule
